FILE: hdl/tatan_pkg.sv
// tatan_pkg: shared types and the tangent table for the table arctangent
// pipeline. No dependencies.
package tatan_pkg;

  localparam int unsigned VecW  = 20;
  localparam int unsigned NumW  = 30;
  localparam int unsigned RomW  = 17;
  localparam int unsigned RomN  = 128;
  localparam int unsigned AngW  = 10;

  localparam logic [AngW-1:0] AngRight = 10'd128;
  localparam logic [AngW-1:0] AngHalf  = 10'd256;
  localparam logic [AngW-1:0] AngFull  = 10'd512;

  // sideband that travels with every item
  typedef struct packed {
    logic       neg_x;
    logic       neg_y;
    logic       spec;
    logic [7:0] spec_a;
  } side_t;

  localparam logic [RomW-1:0] TanRom [RomN] = '{
    17'h00000, 17'h0000c, 17'h00019, 17'h00025, 17'h00032, 17'h0003e, 17'h0004b, 17'h00058,
    17'h00064, 17'h00071, 17'h0007e, 17'h0008b, 17'h00097, 17'h000a4, 17'h000b1, 17'h000be,
    17'h000cb, 17'h000d8, 17'h000e5, 17'h000f3, 17'h00100, 17'h0010d, 17'h0011b, 17'h00128,
    17'h00136, 17'h00144, 17'h00152, 17'h00160, 17'h0016e, 17'h0017c, 17'h0018b, 17'h00199,
    17'h001a8, 17'h001b6, 17'h001c5, 17'h001d5, 17'h001e4, 17'h001f3, 17'h00203, 17'h00213,
    17'h00223, 17'h00233, 17'h00244, 17'h00254, 17'h00265, 17'h00276, 17'h00288, 17'h0029a,
    17'h002ac, 17'h002be, 17'h002d1, 17'h002e4, 17'h002f7, 17'h0030b, 17'h0031f, 17'h00333,
    17'h00348, 17'h0035d, 17'h00373, 17'h00389, 17'h003a0, 17'h003b7, 17'h003ce, 17'h003e7,
    17'h00400, 17'h00419, 17'h00433, 17'h0044e, 17'h00469, 17'h00486, 17'h004a3, 17'h004c0,
    17'h004df, 17'h004ff, 17'h00520, 17'h00541, 17'h00564, 17'h00588, 17'h005ad, 17'h005d4,
    17'h005fc, 17'h00626, 17'h00651, 17'h0067d, 17'h006ac, 17'h006dc, 17'h0070f, 17'h00744,
    17'h0077b, 17'h007b5, 17'h007f2, 17'h00832, 17'h00875, 17'h008bb, 17'h00906, 17'h00954,
    17'h009a8, 17'h00a00, 17'h00a5e, 17'h00ac2, 17'h00b2d, 17'h00ba0, 17'h00c1b, 17'h00ca0,
    17'h00d2f, 17'h00dcb, 17'h00e74, 17'h00f2d, 17'h00ff8, 17'h010d7, 17'h011d0, 17'h012e4,
    17'h0141b, 17'h0157b, 17'h0170d, 17'h018dc, 17'h01af7, 17'h01d73, 17'h0206e, 17'h02411,
    17'h0289c, 17'h02e73, 17'h0363a, 17'h0411b, 17'h0516b, 17'h06c99, 17'h0a2f1, 17'h145ee
  };

endpackage

FILE: hdl/table_arctan2_angle.sv
// Accepts one item per cycle while the output is not stalled; a magnitude stage,
// ten 3-bit restoring divider stages, eight binary-search probe stages and a
// quadrant fold stage.
// A stall at the output freezes the whole pipeline in place.
// Reset (rst_ni low, asynchronous) clears all valid bits; no payload reset.
// table_arctan2_angle: pipelined atan2 by division and tangent table search.
// Depends on tatan_pkg.
module table_arctan2_angle import tatan_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [VecW-1:0] vec_x_i,
  input  logic signed [VecW-1:0] vec_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic        [AngW-1:0] angle_o
);

  localparam int unsigned BitsPerSt = 3;
  localparam int unsigned NDiv      = NumW / BitsPerSt;
  localparam int unsigned NSrch     = 8;

  logic en;
  logic out_vld_q;
  logic [AngW-1:0] angle_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // divider pipeline registers, index 0 is the magnitude stage
  logic            dv_q   [NDiv+1];
  logic [VecW-1:0] dd_q   [NDiv+1];
  logic [VecW-1:0] rr_q   [NDiv+1];
  logic [NumW-1:0] nn_q   [NDiv+1];
  logic [NumW-1:0] qq_q   [NDiv+1];
  side_t           ds_q   [NDiv+1];

  // magnitude stage
  logic [VecW-1:0] ax_d, ay_d;
  side_t           s0_d;
  always_comb begin
    ax_d = vec_x_i[VecW-1] ? (VecW'(0) - vec_x_i) : vec_x_i;
    ay_d = vec_y_i[VecW-1] ? (VecW'(0) - vec_y_i) : vec_y_i;
    s0_d.neg_x  = vec_x_i[VecW-1];
    s0_d.neg_y  = vec_y_i[VecW-1];
    s0_d.spec   = (ax_d == '0) || (ay_d == '0);
    s0_d.spec_a = (ax_d == '0) ? AngRight[7:0] : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q[0] <= ax_d;
      rr_q[0] <= '0;
      nn_q[0] <= {ay_d, (NumW-VecW)'(0)};
      qq_q[0] <= '0;
      ds_q[0] <= s0_d;
    end
  end

  // restoring divider stages, three quotient bits each
  for (genvar k = 1; k <= NDiv; k++) begin : g_div
    logic [VecW-1:0] r_d;
    logic [NumW-1:0] n_d, q_d;
    logic [VecW:0]   rw;
    always_comb begin
      r_d = rr_q[k-1];
      n_d = nn_q[k-1];
      q_d = qq_q[k-1];
      rw  = '0;
      for (int b = 0; b < BitsPerSt; b++) begin
        rw  = {r_d, n_d[NumW-1]};
        n_d = {n_d[NumW-2:0], 1'b0};
        if (rw >= {1'b0, dd_q[k-1]}) begin
          r_d = VecW'(rw - {1'b0, dd_q[k-1]});
          q_d = {q_d[NumW-2:0], 1'b1};
        end else begin
          r_d = rw[VecW-1:0];
          q_d = {q_d[NumW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dd_q[k] <= dd_q[k-1];
        rr_q[k] <= r_d;
        nn_q[k] <= n_d;
        qq_q[k] <= q_d;
        ds_q[k] <= ds_q[k-1];
      end
    end
  end

  // search pipeline registers, index 0 fed from the divider output
  logic              sv_q   [NSrch+1];
  logic [NumW-1:0]   st_q   [NSrch+1];
  logic signed [8:0] lo_q   [NSrch+1];
  logic signed [8:0] hi_q   [NSrch+1];
  logic [6:0]        mid_q  [NSrch+1];
  logic              done_q [NSrch+1];
  side_t             ss_q   [NSrch+1];

  always_comb begin
    sv_q[0]   = dv_q[NDiv];
    st_q[0]   = qq_q[NDiv];
    lo_q[0]   = 9'sd0;
    hi_q[0]   = 9'sd128;
    mid_q[0]  = 7'd0;
    done_q[0] = 1'b0;
    ss_q[0]   = ds_q[NDiv];
  end

  // one probe per stage
  for (genvar k = 1; k <= NSrch; k++) begin : g_srch
    logic signed [8:0] lo_d, hi_d, m;
    logic [6:0]        mid_d;
    logic              done_d;
    logic [RomW-1:0]   ent;
    always_comb begin
      lo_d   = lo_q[k-1];
      hi_d   = hi_q[k-1];
      mid_d  = mid_q[k-1];
      done_d = done_q[k-1];
      m      = (lo_q[k-1] + hi_q[k-1]) >>> 1;
      ent    = TanRom[m[6:0]];
      if (!done_q[k-1] && (lo_q[k-1] < hi_q[k-1])) begin
        mid_d = m[6:0];
        if (st_q[k-1] == NumW'(ent)) begin
          done_d = 1'b1;
        end else if (st_q[k-1] < NumW'(ent)) begin
          hi_d = m - 9'sd1;
        end else begin
          lo_d = m + 9'sd1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en) begin
        sv_q[k] <= sv_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k]   <= st_q[k-1];
        lo_q[k]   <= lo_d;
        hi_q[k]   <= hi_d;
        mid_q[k]  <= mid_d;
        done_q[k] <= done_d;
        ss_q[k]   <= ss_q[k-1];
      end
    end
  end

  // quadrant fold and output register
  logic [AngW-1:0] a_base, a_x, angle_d;
  always_comb begin
    a_base  = ss_q[NSrch].spec ? AngW'(ss_q[NSrch].spec_a) : AngW'(mid_q[NSrch]);
    a_x     = ss_q[NSrch].neg_x ? (AngHalf - a_base) : a_base;
    angle_d = ss_q[NSrch].neg_y ? (AngFull - a_x) : a_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sv_q[NSrch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign angle_o     = angle_q;

  // search always terminates within the probe stages
  a_srch_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[NSrch] && !ss_q[NSrch].spec |-> done_q[NSrch] || !(lo_q[NSrch] < hi_q[NSrch]))
    else $error("search not finished at last stage");

  // angle stays in range
  a_ang_rng : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> angle_q <= AngFull)
    else $error("angle out of range");

  // a stall freezes the last divider and search valid bits and the output angle
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_q[NDiv]) && $stable(sv_q[NSrch]) && $stable(angle_q))
    else $error("pipeline moved during stall");

endmodule

FILE: bench/tatan_checker.sv
// tatan_checker: watches both channels of table_arctan2_angle, predicts each
// angle by table search and compares. Depends on tatan_pkg.
`timescale 1ns / 100ps
module tatan_checker import tatan_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic signed [VecW-1:0] vec_x_i,
  input  logic signed [VecW-1:0] vec_y_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic        [AngW-1:0] angle_i,
  output int                     fail_cnt_o,
  output int                     pending_o,
  output int                     angles_seen_o
);

  // tangent table, 1024 * tan(k/512 turn)
  localparam logic [31:0] TanTab [128] = '{
    32'h0, 32'hc, 32'h19, 32'h25, 32'h32, 32'h3e, 32'h4b, 32'h58,
    32'h64, 32'h71, 32'h7e, 32'h8b, 32'h97, 32'ha4, 32'hb1, 32'hbe,
    32'hcb, 32'hd8, 32'he5, 32'hf3, 32'h100, 32'h10d, 32'h11b, 32'h128,
    32'h136, 32'h144, 32'h152, 32'h160, 32'h16e, 32'h17c, 32'h18b, 32'h199,
    32'h1a8, 32'h1b6, 32'h1c5, 32'h1d5, 32'h1e4, 32'h1f3, 32'h203, 32'h213,
    32'h223, 32'h233, 32'h244, 32'h254, 32'h265, 32'h276, 32'h288, 32'h29a,
    32'h2ac, 32'h2be, 32'h2d1, 32'h2e4, 32'h2f7, 32'h30b, 32'h31f, 32'h333,
    32'h348, 32'h35d, 32'h373, 32'h389, 32'h3a0, 32'h3b7, 32'h3ce, 32'h3e7,
    32'h400, 32'h419, 32'h433, 32'h44e, 32'h469, 32'h486, 32'h4a3, 32'h4c0,
    32'h4df, 32'h4ff, 32'h520, 32'h541, 32'h564, 32'h588, 32'h5ad, 32'h5d4,
    32'h5fc, 32'h626, 32'h651, 32'h67d, 32'h6ac, 32'h6dc, 32'h70f, 32'h744,
    32'h77b, 32'h7b5, 32'h7f2, 32'h832, 32'h875, 32'h8bb, 32'h906, 32'h954,
    32'h9a8, 32'ha00, 32'ha5e, 32'hac2, 32'hb2d, 32'hba0, 32'hc1b, 32'hca0,
    32'hd2f, 32'hdcb, 32'he74, 32'hf2d, 32'hff8, 32'h10d7, 32'h11d0, 32'h12e4,
    32'h141b, 32'h157b, 32'h170d, 32'h18dc, 32'h1af7, 32'h1d73, 32'h206e, 32'h2411,
    32'h289c, 32'h2e73, 32'h363a, 32'h411b, 32'h516b, 32'h6c99, 32'ha2f1, 32'h145ee
  };

  logic [AngW-1:0] angle_q[$];

  // four-quadrant angle of one vector
  function automatic logic [AngW-1:0] vector_angle(logic signed [VecW-1:0] x,
                                                   logic signed [VecW-1:0] y);
    logic [VecW:0] mag_x, mag_y;
    logic [31:0]   ratio;
    int            lo, hi, mid;
    logic [AngW-1:0] a;
    bit            hit;
    mag_x = x[VecW-1] ? (21'd1 << VecW) - {1'b0, x} : {1'b0, x};
    mag_y = y[VecW-1] ? (21'd1 << VecW) - {1'b0, y} : {1'b0, y};
    lo = 0; hi = 128; mid = 0; hit = 0;
    if (mag_x == 0) a = 10'd128;
    else if (mag_y == 0) a = 10'd0;
    else begin
      ratio = 32'((64'(mag_y) << 10) / 64'(mag_x));
      while (lo < hi && !hit) begin
        mid = (lo + hi) >> 1;
        if (ratio == TanTab[mid]) hit = 1;
        else if (ratio < TanTab[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
      a = AngW'(mid);
    end
    if (x[VecW-1]) a = 10'd256 - a;
    if (y[VecW-1]) a = 10'd512 - a;
    return a;
  endfunction

  assign pending_o = angle_q.size();

  // predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) angle_q.push_back(vector_angle(vec_x_i, vec_y_i));
      if (out_valid_i && out_ready_i) begin
        angles_seen_o <= angles_seen_o + 1;
        if (angle_q.size() == 0) begin
          $display("%0t: angle %0d with no item pending", $time, angle_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else if (angle_q[0] !== angle_i) begin
          $display("%0t: angle mismatch expected %0d actual %0d", $time, angle_q[0], angle_i);
          fail_cnt_o <= fail_cnt_o + 1;
          void'(angle_q.pop_front());
        end else void'(angle_q.pop_front());
      end
    end
  end

  initial begin
    fail_cnt_o = 0;
    angles_seen_o = 0;
  end

endmodule

FILE: bench/tb_top.sv
// tb_top: stimulus and verdict for table_arctan2_angle; the checker does the
// prediction. Depends on tatan_pkg, tatan_checker and the block.
`timescale 1ns / 100ps
module tb_top;
  import tatan_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_ready_i = 0;
  logic signed [VecW-1:0] vec_x_i = '0, vec_y_i = '0;
  logic in_ready_o, out_valid_o;
  logic [AngW-1:0] angle_o;
  int fail_cnt, pending, angles_seen;
  int sent_cnt = 0;
  bit sending_done = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  table_arctan2_angle dut (.*);

  tatan_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .vec_x_i, .vec_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .angle_i(angle_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .angles_seen_o(angles_seen)
  );

  // one item through the handshake
  task automatic send_vec(logic signed [VecW-1:0] x, logic signed [VecW-1:0] y);
    vec_x_i <= x;
    vec_y_i <= y;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // random component, often small or at the ends
  function automatic logic [VecW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return VecW'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 20'h80000 : ($urandom_range(0, 1) ? 20'h7ffff : 20'h80001);
      3: return VecW'($urandom_range(0, 2000)) - 20'd1000;
      default: return VecW'($urandom);
    endcase
  endfunction

  // receiver stall pattern
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      mode = (angles_seen / 200) % 3;
      out_ready_i <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                     : ($urandom_range(0, 1) == 1);
    end
  end

  initial begin
    int dirs[16][2];
    int gap;
    int burst;
    dirs = '{'{0, 0}, '{524287, 0}, '{-524287, 0}, '{0, 524287}, '{0, -524287},
             '{-524288, -524288}, '{-524288, 0}, '{0, -524288}, '{524287, 524287},
             '{-524287, 524287}, '{524287, -524287}, '{-524287, -524287},
             '{1, 524287}, '{524287, 1}, '{-1, -1}, '{1024, 1}};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // directed corners
    foreach (dirs[i]) send_vec(VecW'(dirs[i][0]), VecW'(dirs[i][1]));
    // one exact table hit, other ratios between entries, all quadrants
    for (int k = 0; k < 8; k++)
      send_vec(VecW'(k[0] ? -1024 : 1024), VecW'((k[1] ? -1 : 1) * (k * 151 + 12)));
    // random bursts with gaps
    for (int n = 0; n < 1050;) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, n++) send_vec(rand_comp(), rand_comp());
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("sent %0d vectors over all four quadrants and axes, checked %0d angles",
             sent_cnt, angles_seen);
    if (fail_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/tatan_pkg.sv
hdl/table_arctan2_angle.sv
bench/tatan_checker.sv
bench/tb_top.sv
